// ===== sv/rsch_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rsch_pkg
// Types and constants shared by the ray/sphere closest-hit block.
// ============================================================================
package rsch_pkg;

    // Fixed-point format of coordinates and distances
    localparam int FRAC_BITS = 16;

    localparam int COORD_W  = 32;               // origin / center
    localparam int DIR_W    = 18;               // direction components
    localparam int RAD_W    = 31;               // sphere radius
    localparam int IDX_W    = 8;                // object index
    localparam int DIST_W   = 31;               // reported distance
    localparam int BEST_W   = 32;               // best distance register

    localparam int OFS_W    = COORD_W + 1;      // origin - center
    localparam int MUL_W    = OFS_W;            // multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;        // multiplier product width
    localparam int BPROD_W  = OFS_W + DIR_W;    // |oc| * |dir|
    localparam int BACC_W   = BPROD_W + 3;      // b = sum of three products
    localparam int BMAG_W   = BACC_W - 1;       // |b|
    localparam int BLO_W    = 32;               // low split of |b|
    localparam int BHI_W    = BMAG_W - BLO_W;   // high split of |b|
    localparam int DISC_W   = 108;              // discriminant accumulator
    localparam int ROOT_W   = DISC_W / 2;       // square root result
    localparam int REM_W    = ROOT_W + 3;       // root remainder
    localparam int T_W      = ROOT_W + 2;       // t = -b - sqrt(disc)

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_STEPS  = 11;             // ten products plus a drain of the last product
    localparam int SQRT_STEPS = DISC_W / 2;
    localparam int CNT_W      = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          sphere_radius;
        logic [IDX_W-1:0]          object_index;
        logic                      last_sphere;
    } rsch_in_t;

    typedef struct packed {
        logic              hit_found;
        logic [IDX_W-1:0]  closest_index;
        logic [DIST_W-1:0] hit_distance;
    } rsch_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DECIDE,
        ST_SQRT,
        ST_TCALC,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MS_OXDX,
        MS_OYDY,
        MS_OZDZ,
        MS_OXOX,
        MS_OYOY,
        MS_OZOZ,
        MS_RR,
        MS_BLBL,
        MS_BLBH,
        MS_BHBH
    } mul_sel_t;

    typedef enum logic {
        DEST_B,
        DEST_DISC
    } mul_dest_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC2,
        SH_MID,
        SH_HIGH
    } shift_t;

    typedef struct packed {
        logic      in_load;
        logic      setup;
        logic      mul_en;
        mul_sel_t  mul_sel;
        mul_dest_t mul_dest;
        logic      mul_sub;
        shift_t    mul_shift;
        logic      sqrt_init;
        logic      sqrt_step;
        logic      t_calc;
        logic      best_update;
        logic      emit;
    } rsch_cmd_t;

    typedef struct packed {
        logic disc_pos;
        logic last;
    } rsch_status_t;

endpackage

// ===== sv/rsch_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rsch_ctrl
// Sequencer: handshakes, multiply schedule, square-root count, result hand-off.
// ============================================================================
module rsch_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rsch_pkg::rsch_status_t status,
    output rsch_pkg::rsch_cmd_t   cmd
);

    rsch_pkg::state_t            state_reg, state_next;
    logic [rsch_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsch_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == rsch_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_sel  = rsch_pkg::MS_OXDX;
        cmd.mul_dest = rsch_pkg::DEST_B;
        cmd.mul_shift = rsch_pkg::SH_NONE;

        case (state_reg)
            rsch_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = rsch_pkg::ST_LOAD;
                end
            end
            rsch_pkg::ST_LOAD: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = rsch_pkg::ST_MUL;
            end
            rsch_pkg::ST_MUL: begin
                // b first, |b| is needed for the last three products
                cmd.mul_en = 1'b1;
                case (cnt_reg)
                    6'd0: cmd.mul_sel = rsch_pkg::MS_OXDX;
                    6'd1: cmd.mul_sel = rsch_pkg::MS_OYDY;
                    6'd2: cmd.mul_sel = rsch_pkg::MS_OZDZ;
                    6'd3: begin
                        cmd.mul_sel   = rsch_pkg::MS_OXOX;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_sub   = 1'b1;
                        cmd.mul_shift = rsch_pkg::SH_FRAC2;
                    end
                    6'd4: begin
                        cmd.mul_sel   = rsch_pkg::MS_OYOY;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_sub   = 1'b1;
                        cmd.mul_shift = rsch_pkg::SH_FRAC2;
                    end
                    6'd5: begin
                        cmd.mul_sel   = rsch_pkg::MS_OZOZ;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_sub   = 1'b1;
                        cmd.mul_shift = rsch_pkg::SH_FRAC2;
                    end
                    6'd6: begin
                        cmd.mul_sel   = rsch_pkg::MS_RR;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_shift = rsch_pkg::SH_FRAC2;
                    end
                    6'd7: begin
                        cmd.mul_sel   = rsch_pkg::MS_BLBL;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                    end
                    6'd8: begin
                        cmd.mul_sel   = rsch_pkg::MS_BLBH;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_shift = rsch_pkg::SH_MID;
                    end
                    6'd9: begin
                        cmd.mul_sel   = rsch_pkg::MS_BHBH;
                        cmd.mul_dest  = rsch_pkg::DEST_DISC;
                        cmd.mul_shift = rsch_pkg::SH_HIGH;
                    end
                    default: cmd.mul_en = 1'b0;   // drain of the last product
                endcase
                if (cnt_reg == rsch_pkg::CNT_W'(rsch_pkg::MUL_STEPS - 1)) begin
                    state_next = rsch_pkg::ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rsch_pkg::ST_DECIDE: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                if (status.disc_pos) begin
                    state_next = rsch_pkg::ST_SQRT;
                end else if (status.last) begin
                    state_next = rsch_pkg::ST_EMIT;
                end else begin
                    state_next = rsch_pkg::ST_IDLE;
                end
            end
            rsch_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == rsch_pkg::CNT_W'(rsch_pkg::SQRT_STEPS - 1)) begin
                    state_next = rsch_pkg::ST_TCALC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rsch_pkg::ST_TCALC: begin
                cmd.t_calc = 1'b1;
                state_next = rsch_pkg::ST_UPDATE;
            end
            rsch_pkg::ST_UPDATE: begin
                cmd.best_update = 1'b1;
                state_next = status.last ? rsch_pkg::ST_EMIT : rsch_pkg::ST_IDLE;
            end
            rsch_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rsch_pkg::ST_IDLE;
                end
            end
            default: state_next = rsch_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== sv/rsch_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rsch_datapath
// Ray registers, shared multiplier, accumulators, square root, best-hit state.
// ============================================================================
module rsch_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [rsch_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rsch_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  rsch_pkg::rsch_in_t                    s_data,
    output rsch_pkg::rsch_out_t                   m_data,
    input  rsch_pkg::rsch_cmd_t                   cmd,
    output rsch_pkg::rsch_status_t                status
);

    localparam int OW = rsch_pkg::OFS_W;
    localparam int DW = rsch_pkg::DIR_W;

    // ray configuration
    logic signed [rsch_pkg::COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [DW-1:0]                dir_x_reg, dir_y_reg, dir_z_reg;

    // sphere being processed
    rsch_pkg::rsch_in_t in_reg;

    // magnitudes and signs of oc and dir
    logic [OW-1:0] ox_mag_reg, oy_mag_reg, oz_mag_reg;
    logic          ox_neg_reg, oy_neg_reg, oz_neg_reg;
    logic [DW-1:0] dx_mag_reg, dy_mag_reg, dz_mag_reg;
    logic          dx_neg_reg, dy_neg_reg, dz_neg_reg;

    // multiplier pipeline
    logic [rsch_pkg::PROD_W-1:0] prod_reg;
    logic                        pv_reg;
    rsch_pkg::mul_dest_t         pdest_reg;
    logic                        psub_reg;
    rsch_pkg::shift_t            pshift_reg;

    logic signed [rsch_pkg::BACC_W-1:0] b_reg, b_next;
    logic [rsch_pkg::BMAG_W-1:0]        bmag_reg;
    logic [rsch_pkg::DISC_W-1:0]        disc_reg, disc_next;

    // square root
    logic [rsch_pkg::DISC_W-1:0] rad_reg;
    logic [rsch_pkg::REM_W-1:0]  rem_reg;
    logic [rsch_pkg::ROOT_W-1:0] root_reg;

    logic [rsch_pkg::T_W-1:0]    t_reg;

    logic [rsch_pkg::BEST_W-1:0] best_dist_reg;
    logic [rsch_pkg::IDX_W-1:0]  best_idx_reg;
    logic                        any_hit_reg;

    rsch_pkg::rsch_out_t out_reg;

    function automatic logic [OW-1:0] ofs_mag(input logic [OW-1:0] v);
        ofs_mag = v[OW-1] ? (OW'(0) - v) : v;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            dir_z_reg    <= rsch_pkg::DIR_Z_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rsch_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                rsch_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                rsch_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                rsch_pkg::REG_DIR_X:    dir_x_reg    <= cfg_data[DW-1:0];
                rsch_pkg::REG_DIR_Y:    dir_y_reg    <= cfg_data[DW-1:0];
                rsch_pkg::REG_DIR_Z:    dir_z_reg    <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- setup: oc = origin - center ----------------
    logic [OW-1:0] ox_full, oy_full, oz_full;
    assign ox_full = {origin_x_reg[31], origin_x_reg} - {in_reg.center_x[31], in_reg.center_x};
    assign oy_full = {origin_y_reg[31], origin_y_reg} - {in_reg.center_y[31], in_reg.center_y};
    assign oz_full = {origin_z_reg[31], origin_z_reg} - {in_reg.center_z[31], in_reg.center_z};

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_reg <= s_data;
        end
        if (cmd.setup) begin
            ox_mag_reg <= ofs_mag(ox_full);
            oy_mag_reg <= ofs_mag(oy_full);
            oz_mag_reg <= ofs_mag(oz_full);
            ox_neg_reg <= ox_full[OW-1];
            oy_neg_reg <= oy_full[OW-1];
            oz_neg_reg <= oz_full[OW-1];
            dx_mag_reg <= dir_x_reg[DW-1] ? (DW'(0) - dir_x_reg) : dir_x_reg;
            dy_mag_reg <= dir_y_reg[DW-1] ? (DW'(0) - dir_y_reg) : dir_y_reg;
            dz_mag_reg <= dir_z_reg[DW-1] ? (DW'(0) - dir_z_reg) : dir_z_reg;
            dx_neg_reg <= dir_x_reg[DW-1];
            dy_neg_reg <= dir_y_reg[DW-1];
            dz_neg_reg <= dir_z_reg[DW-1];
        end
    end

    // ---------------- shared unsigned multiplier ----------------
    logic [rsch_pkg::MUL_W-1:0] mul_a, mul_b;
    logic                       mul_neg;

    always_comb begin
        mul_a   = ox_mag_reg;
        mul_b   = rsch_pkg::MUL_W'(dx_mag_reg);
        mul_neg = ox_neg_reg ^ dx_neg_reg;
        case (cmd.mul_sel)
            rsch_pkg::MS_OXDX: begin
                mul_a   = ox_mag_reg;
                mul_b   = rsch_pkg::MUL_W'(dx_mag_reg);
                mul_neg = ox_neg_reg ^ dx_neg_reg;
            end
            rsch_pkg::MS_OYDY: begin
                mul_a   = oy_mag_reg;
                mul_b   = rsch_pkg::MUL_W'(dy_mag_reg);
                mul_neg = oy_neg_reg ^ dy_neg_reg;
            end
            rsch_pkg::MS_OZDZ: begin
                mul_a   = oz_mag_reg;
                mul_b   = rsch_pkg::MUL_W'(dz_mag_reg);
                mul_neg = oz_neg_reg ^ dz_neg_reg;
            end
            rsch_pkg::MS_OXOX: begin
                mul_a = ox_mag_reg;
                mul_b = ox_mag_reg;
            end
            rsch_pkg::MS_OYOY: begin
                mul_a = oy_mag_reg;
                mul_b = oy_mag_reg;
            end
            rsch_pkg::MS_OZOZ: begin
                mul_a = oz_mag_reg;
                mul_b = oz_mag_reg;
            end
            rsch_pkg::MS_RR: begin
                mul_a = rsch_pkg::MUL_W'(in_reg.sphere_radius);
                mul_b = rsch_pkg::MUL_W'(in_reg.sphere_radius);
            end
            rsch_pkg::MS_BLBL: begin
                mul_a = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BLO_W-1:0]);
                mul_b = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BLO_W-1:0]);
            end
            rsch_pkg::MS_BLBH: begin
                mul_a = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BLO_W-1:0]);
                mul_b = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BMAG_W-1:rsch_pkg::BLO_W]);
            end
            rsch_pkg::MS_BHBH: begin
                mul_a = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BMAG_W-1:rsch_pkg::BLO_W]);
                mul_b = rsch_pkg::MUL_W'(bmag_reg[rsch_pkg::BMAG_W-1:rsch_pkg::BLO_W]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= rsch_pkg::PROD_W'(mul_a) * rsch_pkg::PROD_W'(mul_b);
        pdest_reg  <= cmd.mul_dest;
        psub_reg   <= (cmd.mul_dest == rsch_pkg::DEST_B) ? mul_neg : cmd.mul_sub;
        pshift_reg <= cmd.mul_shift;
    end

    // ---------------- accumulate ----------------
    logic [rsch_pkg::BACC_W-1:0] b_add;
    logic [rsch_pkg::DISC_W-1:0] d_add;

    always_comb begin
        b_add  = rsch_pkg::BACC_W'(prod_reg[rsch_pkg::BPROD_W-1:0]);
        d_add  = rsch_pkg::DISC_W'(prod_reg);
        case (pshift_reg)
            rsch_pkg::SH_NONE:  d_add = rsch_pkg::DISC_W'(prod_reg);
            rsch_pkg::SH_FRAC2: d_add = rsch_pkg::DISC_W'(prod_reg) << (2 * rsch_pkg::FRAC_BITS);
            rsch_pkg::SH_MID:   d_add = rsch_pkg::DISC_W'(prod_reg) << (rsch_pkg::BLO_W + 1);
            rsch_pkg::SH_HIGH:  d_add = rsch_pkg::DISC_W'(prod_reg) << (2 * rsch_pkg::BLO_W);
            default:            d_add = rsch_pkg::DISC_W'(prod_reg);
        endcase
        b_next    = b_reg;
        disc_next = disc_reg;
        if (cmd.setup) begin
            b_next    = '0;
            disc_next = '0;
        end else if (pv_reg) begin
            if (pdest_reg == rsch_pkg::DEST_B) begin
                b_next = psub_reg ? (b_reg - $signed(b_add)) : (b_reg + $signed(b_add));
            end else begin
                disc_next = psub_reg ? (disc_reg - d_add) : (disc_reg + d_add);
            end
        end
    end

    logic [rsch_pkg::BACC_W-1:0] b_abs;
    assign b_abs = b_reg[rsch_pkg::BACC_W-1] ? (rsch_pkg::BACC_W'(0) - b_reg) : b_reg;

    always_ff @(posedge aclk) begin
        b_reg    <= b_next;
        disc_reg <= disc_next;
        bmag_reg <= b_abs[rsch_pkg::BMAG_W-1:0];
    end

    assign status.disc_pos = !disc_reg[rsch_pkg::DISC_W-1] && (|disc_reg);
    assign status.last     = in_reg.last_sphere;

    // ---------------- square root, two radicand bits per cycle ----------------
    logic [rsch_pkg::REM_W-1:0]  rem_sh, trial;
    logic                        take;

    assign rem_sh = {rem_reg[rsch_pkg::REM_W-3:0], rad_reg[rsch_pkg::DISC_W-1 -: 2]};
    assign trial  = rsch_pkg::REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg  <= disc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[rsch_pkg::ROOT_W-2:0], take};
        end
    end

    // ---------------- t = -b - sqrt(disc) ----------------
    logic [rsch_pkg::T_W-1:0] b_ext;
    assign b_ext = rsch_pkg::T_W'(b_reg);   // b_reg is signed: sign-extends

    always_ff @(posedge aclk) begin
        if (cmd.t_calc) begin
            t_reg <= rsch_pkg::T_W'(0) - b_ext - rsch_pkg::T_W'(root_reg);
        end
    end

    // ---------------- best hit ----------------
    logic                        t_pos;
    logic [rsch_pkg::T_W-1:0]    t_shr;
    logic [rsch_pkg::BEST_W-1:0] t_dist;

    assign t_pos  = !t_reg[rsch_pkg::T_W-1] && (|t_reg);
    assign t_shr  = t_reg >> rsch_pkg::FRAC_BITS;
    assign t_dist = (|t_shr[rsch_pkg::T_W-1:rsch_pkg::DIST_W])
                  ? rsch_pkg::BEST_W'({rsch_pkg::DIST_W{1'b1}})
                  : rsch_pkg::BEST_W'(t_shr[rsch_pkg::DIST_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
        end else if (cmd.emit) begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
        end else if (cmd.best_update && t_pos && (t_dist < best_dist_reg)) begin
            best_dist_reg <= t_dist;
            best_idx_reg  <= in_reg.object_index;
            any_hit_reg   <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.hit_found     <= any_hit_reg;
            out_reg.closest_index <= any_hit_reg ? best_idx_reg : '0;
            out_reg.hit_distance  <= any_hit_reg ? best_dist_reg[rsch_pkg::DIST_W-1:0] : '0;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== sv/ray_sphere_closest_hit_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ray_sphere_closest_hit_top
// Closest ray/sphere hit over a streamed set of spheres, Q16.16 fixed point.
// ============================================================================
// Usage:
//  - cfg_* write channel loads the ray: index 0..2 origin x/y/z, 3..5 dir x/y/z.
//    cfg_ready is always high; writes to other indexes are dropped. Write only
//    while no sphere is in flight.
//  - s_* channel takes one sphere per transaction (center, radius, index, last).
//  - m_* channel returns one transaction per set, after the sphere marked last:
//    hit flag, nearest index and distance (both 0 when nothing was hit).
// Steps per sphere, accept to next accept:
//  - disc <= 0: accept, setup, ten products on the one shared 33x33 multiplier
//    and a drain, decide; an emit step follows on the last sphere of a set.
//  - disc > 0: the same steps up to decide, then the square root (two radicand
//    bits per cycle), t and the compare; emit follows on the last sphere.
// The result leaves through the hand-off (emit) state after the last sphere
// of a set.
// The result sits in an output register, so the next sphere is accepted while
// it waits. If the receiver stalls and another set ends, the block holds in
// its hand-off state until the pending result is taken.
// Reset (aresetn low, synchronous): origin and dir x/y cleared, dir z = 1.0,
// best-hit state cleared, both channels idle.
// ============================================================================
module ray_sphere_closest_hit_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsch_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsch_pkg::CFG_DATA_W-1:0]  cfg_data,
    // sphere input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rsch_pkg::rsch_in_t               s_data,
    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output rsch_pkg::rsch_out_t              m_data
);

    rsch_pkg::rsch_cmd_t    cmd;
    rsch_pkg::rsch_status_t status;
    logic                   cfg_we;

    // Register writes see no back-pressure.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    rsch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rsch_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tb_ray_sphere_closest_hit_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_ray_sphere_closest_hit_top
// Self-checking bench for the streamed ray/sphere closest-hit block.
// Each accepted sphere is traced against a mirror of the ray registers in
// exact wide integer arithmetic. The set result that the last sphere closes
// is queued and compared field by field with what the block returns. Both
// handshakes idle and stall at random.
// ============================================================================
module tb_ray_sphere_closest_hit_top;

    localparam int Q1           = 1 << rsch_pkg::FRAC_BITS;   // 1.0 in Q16.16
    localparam int DRAIN_CYCLES = 80;               // longer than the slowest sphere
    localparam int STALL_LIMIT  = 4000;             // cycles with no transaction
    localparam int REPORT_MAX   = 10;

    // Indexes that decode to no register; writes there must be dropped
    localparam logic [rsch_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd6;
    localparam logic [rsch_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    localparam bit [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam bit [31:0] C_MIN = 32'h8000_0000;
    localparam bit [31:0] R_MAX = 32'h7FFF_FFFF;

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O; every input is known from time zero
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rsch_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rsch_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rsch_pkg::rsch_in_t   s_data  = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rsch_pkg::rsch_out_t  m_data;

    always #5 aclk = ~aclk;

    ray_sphere_closest_hit_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------------
    // Mirror of the ray registers and of the running nearest hit
    // ------------------------------------------------------------------------
    bit signed [rsch_pkg::COORD_W-1:0] ray_ox, ray_oy, ray_oz;
    bit signed [rsch_pkg::DIR_W-1:0]   ray_dx, ray_dy, ray_dz;
    bit [rsch_pkg::BEST_W-1:0]         near_dist = '1;
    bit [rsch_pkg::IDX_W-1:0]          near_idx  = '0;
    bit                                near_any  = 1'b0;

    rsch_pkg::rsch_out_t pending_hits[$];     // set results still owed by the block

    // Idle controls, flipped per phase so some stretches run flat out
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;

    int mismatches   = 0;
    int sphere_count = 0;
    int set_count    = 0;
    int hit_sets     = 0;
    int ray_count    = 0;
    int idle_cycles  = 0;
    int sink_hold    = 0;

    // Floor square root of a 128-bit radicand, one result bit per pass
    function automatic bit [63:0] floor_sqrt(input bit [127:0] v);
        bit [63:0]  root;
        bit [127:0] cand;
        root = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = 128'(root | (64'd1 << k));
            if (cand * cand <= v) begin
                root = cand[63:0];
            end
        end
        return root;
    endfunction

    // Trace one sphere against the current ray. Returns 1 when the sphere
    // closes its set, with the set result in res; the nearest hit is cleared.
    function automatic bit trace_sphere(input rsch_pkg::rsch_in_t sp,
                                        output rsch_pkg::rsch_out_t res);
        longint     ox, oy, oz, b, t;
        bit [127:0] ax, ay, az, bm, rr, pos, neg;
        bit [63:0]  tq;
        res = '0;
        ox  = longint'(ray_ox) - longint'($signed(sp.center_x));
        oy  = longint'(ray_oy) - longint'($signed(sp.center_y));
        oz  = longint'(ray_oz) - longint'($signed(sp.center_z));
        // b keeps 32 fraction bits, the discriminant 64; both are exact
        b   = ox * longint'(ray_dx) + oy * longint'(ray_dy) + oz * longint'(ray_dz);
        ax  = 128'(ox < 0 ? -ox : ox);
        ay  = 128'(oy < 0 ? -oy : oy);
        az  = 128'(oz < 0 ? -oz : oz);
        bm  = 128'(b < 0 ? -b : b);
        rr  = 128'(sp.sphere_radius);
        pos = bm * bm + ((rr * rr) << (2 * rsch_pkg::FRAC_BITS));
        neg = (ax * ax + ay * ay + az * az) << (2 * rsch_pkg::FRAC_BITS);
        // disc == 0 (tangent) is a miss; the near root must lie ahead
        if (pos > neg) begin
            t = -b - longint'(floor_sqrt(pos - neg));
            if (t > 0) begin
                tq = 64'(t) >> rsch_pkg::FRAC_BITS;
                if (tq > 64'h7FFF_FFFF) begin
                    tq = 64'h7FFF_FFFF;
                end
                // strictly nearer only, so the earlier sphere keeps a tie
                if (tq < 64'(near_dist)) begin
                    near_dist = tq[rsch_pkg::BEST_W-1:0];
                    near_idx  = sp.object_index;
                    near_any  = 1'b1;
                end
            end
        end
        if (!sp.last_sphere) begin
            return 1'b0;
        end
        res.hit_found     = near_any;
        res.closest_index = near_any ? near_idx : '0;
        res.hit_distance  = near_any ? near_dist[rsch_pkg::DIST_W-1:0] : '0;
        near_dist = '1;
        near_idx  = '0;
        near_any  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void mirror_reg(input logic [rsch_pkg::CFG_IDX_W-1:0] idx,
                                       input bit [31:0] data);
        case (idx)
            rsch_pkg::REG_ORIGIN_X: ray_ox = data;
            rsch_pkg::REG_ORIGIN_Y: ray_oy = data;
            rsch_pkg::REG_ORIGIN_Z: ray_oz = data;
            rsch_pkg::REG_DIR_X:    ray_dx = data[rsch_pkg::DIR_W-1:0];
            rsch_pkg::REG_DIR_Y:    ray_dy = data[rsch_pkg::DIR_W-1:0];
            rsch_pkg::REG_DIR_Z:    ray_dz = data[rsch_pkg::DIR_W-1:0];
            default:      ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!src_gaps_on || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic rsch_pkg::rsch_in_t ball(input bit [31:0] cx, cy, cz,
                                                input bit [31:0] r, input bit [7:0] idx,
                                                input bit last);
        rsch_pkg::rsch_in_t sp;
        sp.center_x      = cx;
        sp.center_y      = cy;
        sp.center_z      = cz;
        sp.sphere_radius = r[rsch_pkg::RAD_W-1:0];
        sp.object_index  = idx;
        sp.last_sphere   = last;
        return sp;
    endfunction

    // One sphere transaction. Called right after a rising edge; valid is
    // left high on return so the next sphere can follow with no bubble.
    task automatic send_sphere(input rsch_pkg::rsch_in_t sp);
        int                  gap;
        rsch_pkg::rsch_out_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= sp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sphere_count++;
        if (trace_sphere(sp, res)) begin
            pending_hits = {pending_hits, res};
            set_count++;
            if (res.hit_found) hit_sets++;
        end
    endtask

    // Hold the sender until every owed result is back, then let the last
    // sphere drain before anything touches the ray registers
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rsch_pkg::CFG_IDX_W-1:0] idx,
                             input bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mirror_reg(idx, data);
    endtask

    // Load a full ray while the block is idle; junk adds writes to unused slots
    task automatic load_ray(input bit [31:0] ox, oy, oz, dx, dy, dz, input bit junk);
        drain();
        write_reg(rsch_pkg::REG_ORIGIN_X, ox);
        write_reg(rsch_pkg::REG_ORIGIN_Y, oy);
        write_reg(rsch_pkg::REG_ORIGIN_Z, oz);
        write_reg(rsch_pkg::REG_DIR_X, dx);
        write_reg(rsch_pkg::REG_DIR_Y, dy);
        write_reg(rsch_pkg::REG_DIR_Z, dz);
        if (junk) begin
            write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
            write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
        end
        cfg_valid <= 1'b0;
        ray_count++;
    endtask

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------
    function automatic longint jitter(input longint j);
        if (j <= 0) return 0;
        return longint'($urandom_range(0, 32'(2 * j))) - j;
    endfunction

    function automatic bit [31:0] flip(input int v);
        return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
    endfunction

    function automatic bit [31:0] pick_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($urandom_range(0, 4000 * Q1)) - 32'(2000 * Q1);
    endfunction

    // The largest share of spheres sit on or near the ray so the compare path gets exercised;
    // the rest graze, enclose the origin, lie behind, lie far off, or are noise
    function automatic rsch_pkg::rsch_in_t make_sphere();
        rsch_pkg::rsch_in_t sp;
        int                 shape;
        longint             s, r, j;
        shape = $urandom_range(0, 99);
        sp.object_index = 8'($urandom);
        sp.last_sphere  = 1'b0;
        if (shape < 15) begin
            sp.center_x      = $urandom;
            sp.center_y      = $urandom;
            sp.center_z      = $urandom;
            sp.sphere_radius = 31'($urandom);
            return sp;
        end
        s = longint'($urandom_range(0, 2000 * Q1));
        r = longint'($urandom_range(1, 64 * Q1));
        j = r / 2;
        if (shape >= 60 && shape < 75) begin
            j = 2 * r;
        end else if (shape >= 75 && shape < 85) begin
            s = longint'($urandom_range(0, 4 * Q1));
            r = longint'($urandom_range(8 * Q1, 500 * Q1));
            j = Q1;
        end else if (shape >= 85 && shape < 92) begin
            s = -s;
        end else if (shape >= 92) begin
            s = longint'($urandom_range(30000 * Q1, 32'h7FFF_FFFF));
        end
        sp.center_x = 32'(longint'(ray_ox)
                          + ((s * longint'(ray_dx)) >>> rsch_pkg::FRAC_BITS)
                          + jitter(j));
        sp.center_y = 32'(longint'(ray_oy)
                          + ((s * longint'(ray_dy)) >>> rsch_pkg::FRAC_BITS)
                          + jitter(j));
        sp.center_z = 32'(longint'(ray_oz)
                          + ((s * longint'(ray_dz)) >>> rsch_pkg::FRAC_BITS)
                          + jitter(j));
        sp.sphere_radius = 31'(r);
        return sp;
    endfunction

    task automatic random_ray();
        bit [31:0] dx, dy, dz;
        int        axis;
        dx = '0;
        dy = '0;
        dz = '0;
        case ($urandom_range(0, 4))
            0, 1: begin
                axis = $urandom_range(0, 2);
                if (axis == 0) dx = flip(Q1);
                else if (axis == 1) dy = flip(Q1);
                else dz = flip(Q1);
            end
            2: begin
                dx = flip(46341);
                dy = flip(46341);
            end
            3: begin
                dx = flip(37837);
                dy = flip(37837);
                dz = flip(37837);
            end
            default: begin
                // any 18-bit direction, junk in the bits above it
                dx = $urandom;
                dy = $urandom;
                dz = $urandom;
            end
        endcase
        load_ray(pick_coord(), pick_coord(), pick_coord(), dx, dy, dz, 1'b0);
    endtask

    function automatic int pick_set_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 1;
        if (roll < 85) return $urandom_range(2, 8);
        return $urandom_range(9, 30);
    endfunction

    task automatic send_set(input int n);
        rsch_pkg::rsch_in_t sp;
        for (int k = 0; k < n; k++) begin
            sp = make_sphere();
            sp.last_sphere = (k == n - 1);
            send_sphere(sp);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset ray: origin at zero looking down +z
    task automatic test_reset_ray();
        send_sphere(ball(0, 0, 10 * Q1, Q1, 8'd0, 1'b0));       // ahead, t = 9
        send_sphere(ball(0, 0, -10 * Q1, Q1, 8'd1, 1'b0));      // behind
        send_sphere(ball(Q1, 0, 10 * Q1, Q1, 8'd2, 1'b0));      // tangent
        send_sphere(ball(0, 0, Q1 / 2, 2 * Q1, 8'd3, 1'b0));    // origin inside
        send_sphere(ball(0, 0, 10 * Q1, Q1, 8'd255, 1'b1));     // tie: index 0 stays
        send_sphere(ball(0, 0, -10 * Q1, Q1, 8'd4, 1'b1));      // set with no hit
        send_sphere(ball(3, 0, Q1 + 1, Q1, 8'd5, 1'b1));        // near root just ahead
        send_sphere(ball(0, 0, 5 * Q1, '0, 8'd6, 1'b1));        // zero radius
        send_sphere(ball(0, 0, 20 * Q1, Q1, 8'd7, 1'b0));
        send_sphere(ball(0, 0, 5 * Q1, Q1, 8'd8, 1'b1));        // later and nearer wins
        send_sphere(ball(C_MAX, C_MAX, C_MAX, R_MAX, 8'd255, 1'b1));
        send_sphere(ball(C_MIN, C_MIN, C_MIN, R_MAX, 8'd0, 1'b1));
    endtask

    // Register extremes, out-of-range directions, saturated distances
    task automatic test_ray_extremes();
        load_ray(0, 0, C_MIN, 0, 0, Q1, 1'b0);
        send_sphere(ball(0, 0, C_MAX, Q1, 8'd11, 1'b0));        // saturates
        send_sphere(ball(0, 0, C_MAX, 2 * Q1, 8'd12, 1'b1));    // saturated tie
        load_ray(C_MAX, C_MIN, 0, flip(Q1) | 32'h8000_0000, 0, 0, 1'b0);
        @(posedge aclk);
        write_reg(rsch_pkg::REG_DIR_X, 32'(-Q1));
        cfg_valid <= 1'b0;
        send_sphere(ball(C_MAX - 10 * Q1, C_MIN, 0, Q1, 8'd13, 1'b0));
        send_sphere(ball(C_MIN, C_MIN, 0, 3 * Q1, 8'd14, 1'b1));
        // 18-bit direction extremes; dir z carries junk above bit 17 (= 1.0)
        load_ray(0, 0, 0, 32'(131071), 32'hFFFE_0000, 32'hABCD_0000, 1'b1);
        send_sphere(ball(10 * Q1, -10 * Q1, 0, Q1, 8'd15, 1'b0));
        send_sphere(ball(C_MAX, C_MIN, 0, R_MAX, 8'd16, 1'b0));
        send_sphere(ball(0, 0, 3 * Q1, Q1, 8'd17, 1'b1));
        load_ray(C_MIN, C_MIN, C_MIN, 0, 0, 32'(-Q1), 1'b0);
        send_sphere(ball(C_MIN, C_MIN, C_MIN + 5 * Q1, Q1, 8'd18, 1'b1));
    endtask

    // Bulk random sets over many rays, with the idle pattern varied per ray
    task automatic test_random_sets();
        int sent;
        int n;
        for (int ray = 0; ray < 12; ray++) begin
            random_ray();
            src_gaps_on    = (ray % 4 == 0) || (ray % 4 == 2);
            sink_stalls_on = (ray % 4 == 0) || (ray % 4 == 1);
            sent = 0;
            if (ray == 0) begin
                // one set longer than the nominal object limit
                send_set(260);
                sent = 260;
            end
            while (sent < 118) begin
                n = pick_set_len();
                send_set(n);
                sent += n;
            end
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, mostly short, a few long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!sink_stalls_on) begin
            m_ready <= 1'b1;
        end else if (m_ready) begin
            m_ready   <= 1'b0;
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 3);
        end else begin
            m_ready   <= 1'b1;
            sink_hold <= $urandom_range(0, 20);
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every result transaction against the oldest set result
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string why, input rsch_pkg::rsch_out_t want,
                                input rsch_pkg::rsch_out_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] mismatch %s: want %0b/%0d/0x%08h got %0b/%0d/0x%08h",
                     $time, why, want.hit_found, want.closest_index, want.hit_distance,
                     got.hit_found, got.closest_index, got.hit_distance);
        end
    endtask

    rsch_pkg::rsch_out_t want_res;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                log_mismatch("no result owed", '0, m_data);
            end else begin
                want_res = pending_hits.pop_front();
                if (m_data.hit_found !== want_res.hit_found) begin
                    log_mismatch("hit_found", want_res, m_data);
                end else if (m_data.closest_index !== want_res.closest_index) begin
                    log_mismatch("closest_index", want_res, m_data);
                end else if (m_data.hit_distance !== want_res.hit_distance) begin
                    log_mismatch("hit_distance", want_res, m_data);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles, %0d results owed",
                     $time, idle_cycles, pending_hits.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        ray_ox = '0;
        ray_oy = '0;
        ray_oz = '0;
        ray_dx = '0;
        ray_dy = '0;
        ray_dz = rsch_pkg::DIR_Z_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_ray();
        test_ray_extremes();
        test_random_sets();
        drain();

        $display("Run: %0d spheres in %0d sets over %0d ray settings, %0d sets hit.",
                 sphere_count, set_count, ray_count, hit_sets);
        $display("Mismatches: %0d, results still owed: %0d", mismatches,
                 pending_hits.size());
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rsch_pkg.sv
sv/rsch_ctrl.sv
sv/rsch_datapath.sv
sv/ray_sphere_closest_hit_top.sv
tb/tb_ray_sphere_closest_hit_top.sv
